/* rtl/integer_pixel_replicate_upscaler_defines.svh */
// Assertion macros for the upscaler RTL.
`ifndef INTEGER_PIXEL_REPLICATE_UPSCALER_DEFINES_SVH
`define INTEGER_PIXEL_REPLICATE_UPSCALER_DEFINES_SVH

// Plain property check, clocked on clk, off during reset.
`define IPRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define IPRU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/ipru_pkg.sv */
// Shared types and constants for the integer pixel replicate upscaler.
package ipru_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_SCALE  = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 13;
    localparam int SCALE_W    = 5;
    localparam int PASS_W     = 4;
    localparam int HEIGHT_W   = 16;
    localparam int PIX_W      = 24;
    localparam int PAD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_REPLAY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               order_error;
        logic               from_mem;
        logic [SCALE_W-1:0] repeat_count;
        logic [PAD_W-1:0]   pad_bytes;
        logic               row_end;
        logic               image_end;
    } run_info_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [COL_W-1:0] addr;
    } mem_req_t;

endpackage

/* rtl/ipru_line_store.sv */
// Single-port line store, one source row of pixels, registered read.
module ipru_line_store
(
    input  logic                     clk,
    input  ipru_pkg::mem_req_t       req,
    input  logic [ipru_pkg::PIX_W-1:0] wdata,
    output logic [ipru_pkg::PIX_W-1:0] rdata
);
    import ipru_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ipru_ctrl.sv */
// Configuration registers, row/pass/column counters and per-request decode.
module ipru_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          accept,
    input  logic                          cmd,
    output ipru_pkg::run_info_t           info,
    output ipru_pkg::mem_req_t            mem_req
);
    import ipru_pkg::*;

    logic [SCALE_W-1:0]  scale_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic                replay_reg, replay_next;

    logic [SCALE_W-1:0]  scale_eff;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic                err;
    logic                col_last, pass_last, row_last;
    logic [3:0]          pad_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (scale_reg == '0)
            scale_eff = SCALE_W'(1);
        else if (scale_reg > SCALE_W'(MAX_SCALE))
            scale_eff = SCALE_W'(MAX_SCALE);
        else
            scale_eff = scale_reg;

        if (width_reg == '0)
            width_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            width_eff = WIDTH_W'(MAX_WIDTH);
        else
            width_eff = width_reg;

        height_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign err       = (cmd == CMD_REPLAY) != replay_reg;
    assign col_last  = ({1'b0, col_reg} + WIDTH_W'(1)) >= width_eff;
    assign pass_last = ({1'b0, pass_reg} + SCALE_W'(1)) >= scale_eff;
    assign row_last  = ({1'b0, row_reg} + 17'd1) >= {1'b0, height_eff};
    // pad = (-(3*w*s)) mod 4 = (w*s) mod 4
    assign pad_prod  = width_eff[1:0] * scale_eff[1:0];

    always_comb
    begin
        col_next    = col_reg;
        pass_next   = pass_reg;
        row_next    = row_reg;
        replay_next = replay_reg;
        if (accept && !err)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (pass_last)
                begin
                    pass_next   = '0;
                    replay_next = 1'b0;
                    row_next    = row_last ? '0 : row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    pass_next   = pass_reg + PASS_W'(1);
                    replay_next = 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            pass_reg   <= '0;
            row_reg    <= '0;
            replay_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            pass_reg   <= pass_next;
            row_reg    <= row_next;
            replay_reg <= replay_next;
        end
    end

    always_comb
    begin
        info.order_error  = err;
        info.from_mem     = !err && replay_reg;
        info.repeat_count = err ? '0 : scale_eff;
        info.pad_bytes    = (!err && col_last) ? pad_prod[1:0] : '0;
        info.row_end      = !err && col_last;
        info.image_end    = !err && col_last && pass_last && row_last;
    end

    assign mem_req.wr_en = accept && !err && !replay_reg;
    assign mem_req.rd_en = accept && !err && replay_reg;
    assign mem_req.addr  = col_reg;

endmodule

/* rtl/integer_pixel_replicate_upscaler.sv */
// Top level: nearest-neighbor integer upscaler for 24-bit pixel rows.
// Pipeline: a stage-1 register (line store read in flight), then the output register.
// Throughput: one request per clock while out_ready is high; the single-port line store
//   serves one write (source pixel) or one read (replay) per cycle.
// Reset: counters clear, scale/width/height return to 1, pipeline empties;
//   the line store is not cleared and is written by the first source row.
module integer_pixel_replicate_upscaler
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [ipru_pkg::PIX_W-1:0]      pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ipru_pkg::PIX_W-1:0]      pixel_out,
    output logic [ipru_pkg::SCALE_W-1:0]    repeat_count,
    output logic [ipru_pkg::PAD_W-1:0]      pad_bytes,
    output logic                            row_end,
    output logic                            image_end,
    output logic                            order_error
);
    import ipru_pkg::*;
    `include "integer_pixel_replicate_upscaler_defines.svh"

    logic             accept;
    logic             s1_go;
    run_info_t        info;
    mem_req_t         mem_req;
    logic [PIX_W-1:0] mem_rdata;

    logic             s1_valid_reg;
    run_info_t        s1_info_reg;
    logic [PIX_W-1:0] s1_pix_reg;

    logic             out_valid_reg;
    run_info_t        out_info_reg;
    logic [PIX_W-1:0] out_pix_reg;

    assign s1_go    = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    ipru_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (cmd),
        .info      (info),
        .mem_req   (mem_req)
    );

    ipru_line_store u_line_store
    (
        .clk   (clk),
        .req   (mem_req),
        .wdata (pixel_in),
        .rdata (mem_rdata)
    );

    // Stage 1: line store read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
            s1_pix_reg  <= info.order_error ? '0 : pixel_in;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_valid_reg)
        begin
            out_info_reg <= s1_info_reg;
            out_pix_reg  <= s1_info_reg.from_mem ? mem_rdata : s1_pix_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = out_pix_reg;
    assign repeat_count = out_info_reg.repeat_count;
    assign pad_bytes    = out_info_reg.pad_bytes;
    assign row_end      = out_info_reg.row_end;
    assign image_end    = out_info_reg.image_end;
    assign order_error  = out_info_reg.order_error;

    `IPRU_ASSERT(a_rdata_hold, s1_valid_reg && !s1_go |=> $stable(mem_rdata), "read data lost while stalled")
    `IPRU_ASSERT_IMPL(a_err_clean, out_valid_reg && order_error, repeat_count == '0 && !row_end && !image_end, "error result carries run data")
    `IPRU_ASSERT_IMPL(a_img_row, out_valid_reg && image_end, row_end, "image end without row end")
    `IPRU_ASSERT_IMPL(a_pad_row, out_valid_reg && pad_bytes != '0, row_end, "padding away from row end")

endmodule
